[hdl/aes_round_aead_cipher_assert.svh]
// Assertion macros for the cipher block
`ifndef AES_ROUND_AEAD_CIPHER_ASSERT_SVH
`define AES_ROUND_AEAD_CIPHER_ASSERT_SVH
`define ARAC_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define ARAC_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");
`endif

[hdl/arac_pkg.sv]
// ----------------------------------------------------------------------------
// arac_pkg: shared types, constants and AES round function
// ----------------------------------------------------------------------------
package arac_pkg;
  localparam logic [2:0] CMD_INIT = 3'd0;
  localparam logic [2:0] CMD_AD   = 3'd1;
  localparam logic [2:0] CMD_ENC  = 3'd2;
  localparam logic [2:0] CMD_DEC  = 3'd3;
  localparam logic [2:0] CMD_FIN  = 3'd4;
  localparam int unsigned ROUNDS  = 20;
  localparam logic [4:0] LAST_ROUND = 5'(ROUNDS - 1);
  localparam logic [127:0] Z0 = 128'h428a2f98d728ae22_7137449123ef65cd;
  localparam logic [127:0] Z1 = 128'hb5c0fbcfec4d3b2f_e9b5dba58189dbbc;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] data_0;
    logic [63:0] data_1;
    logic [63:0] data_2;
    logic [63:0] data_3;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] out_0;
    logic [63:0] out_1;
    logic [63:0] out_2;
    logic [63:0] out_3;
  } rsp_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i sits at bits 8i+7:8i
  function automatic logic [127:0] aes_round(input logic [127:0] a, input logic [127:0] k);
    logic [7:0] s [16];
    logic [127:0] o;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        s[r + 4*c] = SBOX[a[8*(r + 4*((c + r) % 4)) +: 8]];
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
      o[8*(4*c)   +: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      o[8*(4*c+1) +: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      o[8*(4*c+2) +: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      o[8*(4*c+3) +: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return o ^ k;
  endfunction
endpackage

[hdl/arac_front.sv]
// ----------------------------------------------------------------------------
// arac_front: request intake, command filter and two-entry queue
// ----------------------------------------------------------------------------
module arac_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           valid,
  output logic           ready,
  input  arac_pkg::req_t req,
  output logic           q_valid,
  input  logic           q_ready,
  output arac_pkg::req_t q_req
);
  import arac_pkg::*;
  `include "aes_round_aead_cipher_assert.svh"

  req_t       mem [2];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop, known;

  assign known   = (req.cmd == CMD_INIT) || (req.cmd == CMD_AD) || (req.cmd == CMD_ENC) ||
                   (req.cmd == CMD_DEC) || (req.cmd == CMD_FIN);
  assign ready   = (count != 2'd2);
  assign push    = valid && ready && known;
  assign q_valid = (count != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_req   = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= req;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  `ARAC_ASSERT_IMP(a_no_overflow, clk, rst, count == 2'd2, !push)
  `ARAC_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count != 2'd3)
  `ARAC_ASSERT_NEXT(a_pop_empty, clk, rst, count == 2'd1 && pop && !push, !q_valid)
endmodule

[hdl/arac_core.sv]
// ----------------------------------------------------------------------------
// arac_core: state update rounds, keystream and tag, output register
// ----------------------------------------------------------------------------
module arac_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  arac_pkg::req_t q_req,
  input  logic [255:0]   key,
  output logic           out_valid,
  input  logic           out_ready,
  output arac_pkg::rsp_t rsp
);
  import arac_pkg::*;
  `include "aes_round_aead_cipher_assert.svh"

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;

  logic [127:0] s [8];
  logic [127:0] s_next [8];
  logic [127:0] src [8];
  logic [127:0] x0, x1, ux0, ux1, ks0, ks1, r0, r1, tag;
  logic [60:0]  ad_cnt, msg_cnt;
  logic [1:0]   state;
  logic [4:0]   rnd;
  logic         is_fin;
  logic         take, out_free, fin_done, out_set;
  rsp_t         rsp_next;

  assign out_free = !out_valid || out_ready;
  assign q_ready  = (state == ST_IDLE) && out_free;
  assign take     = q_valid && q_ready;
  assign fin_done = (state == ST_RUN) && is_fin && (rnd == 5'(ROUNDS));
  assign out_set  = (take && (q_req.cmd == CMD_ENC || q_req.cmd == CMD_DEC)) ||
                    (fin_done && out_free);

  always_comb begin
    for (int i = 0; i < 8; i++) src[i] = s[i];
    x0 = Z0;
    x1 = Z1;
    if (state == ST_RUN) begin
      x0 = is_fin ? {64'd0, ad_cnt, 3'd0} : Z0;
      x1 = is_fin ? {64'd0, msg_cnt, 3'd0} : Z1;
    end else if (q_req.cmd == CMD_INIT) begin
      src[0] = key[255:128];
      src[1] = {q_req.data_1, q_req.data_0};
      src[2] = Z0;
      src[3] = Z1;
      src[4] = src[1] ^ src[0];
      src[5] = '0;
      src[6] = key[127:0];
      src[7] = '0;
    end
    ks0 = aes_round(s[1], s[5]);
    ks1 = aes_round(s[0] ^ s[4], s[2]);
    r0  = {q_req.data_1, q_req.data_0} ^ ks0;
    r1  = {q_req.data_3, q_req.data_2} ^ ks1;
    ux0 = x0;
    ux1 = x1;
    if (state == ST_IDLE && q_req.cmd != CMD_INIT) begin
      ux0 = (q_req.cmd == CMD_DEC) ? r0 : {q_req.data_1, q_req.data_0};
      ux1 = (q_req.cmd == CMD_DEC) ? r1 : {q_req.data_3, q_req.data_2};
    end
    s_next[7] = src[6] ^ src[0];
    s_next[6] = aes_round(src[5], src[4]);
    s_next[5] = aes_round(src[4], src[3]);
    s_next[4] = src[3] ^ ux1;
    s_next[3] = aes_round(src[2], src[1]);
    s_next[2] = src[1] ^ src[6];
    s_next[1] = aes_round(src[0], src[7]);
    s_next[0] = src[7] ^ ux0;
    tag = s[0] ^ s[1] ^ s[2] ^ s[3] ^ s[4] ^ s[5] ^ s[6] ^ s[7];
    rsp_next.kind  = 1'b0;
    rsp_next.out_0 = r0[63:0];
    rsp_next.out_1 = r0[127:64];
    rsp_next.out_2 = r1[63:0];
    rsp_next.out_3 = r1[127:64];
    if (state == ST_RUN) begin
      rsp_next.kind  = 1'b1;
      rsp_next.out_0 = tag[63:0];
      rsp_next.out_1 = tag[127:64];
      rsp_next.out_2 = '0;
      rsp_next.out_3 = '0;
    end
  end

  // keep the state across finalize: save and restore
  logic [127:0] save [8];

  always_ff @(posedge clk) begin
    if (take && q_req.cmd == CMD_FIN) begin
      for (int i = 0; i < 8; i++) save[i] <= s[i];
    end
    if (out_set) begin
      rsp <= rsp_next;
    end
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      is_fin    <= 1'b0;
      out_valid <= 1'b0;
      ad_cnt    <= '0;
      msg_cnt   <= '0;
      for (int i = 0; i < 8; i++) s[i] <= '0;
    end else begin
      if (out_set) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            priority case (q_req.cmd)
              CMD_INIT: begin
                for (int i = 0; i < 8; i++) s[i] <= s_next[i];
                ad_cnt  <= '0;
                msg_cnt <= '0;
                is_fin  <= 1'b0;
                rnd     <= 5'd1;
                state   <= ST_RUN;
              end
              CMD_AD: begin
                for (int i = 0; i < 8; i++) s[i] <= s_next[i];
                ad_cnt <= ad_cnt + 61'd32;
              end
              CMD_ENC, CMD_DEC: begin
                for (int i = 0; i < 8; i++) s[i] <= s_next[i];
                msg_cnt <= msg_cnt + 61'd32;
              end
              CMD_FIN: begin
                is_fin <= 1'b1;
                rnd    <= 5'd0;
                state  <= ST_RUN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RUN: begin
          if (fin_done) begin
            if (out_free) begin
              for (int i = 0; i < 8; i++) s[i] <= save[i];
              state <= ST_IDLE;
            end
          end else begin
            for (int i = 0; i < 8; i++) s[i] <= s_next[i];
            rnd <= rnd + 5'd1;
            if (!is_fin && rnd == LAST_ROUND) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ARAC_ASSERT_IMP(a_run_no_take, clk, rst, state == ST_RUN, !q_ready)
  `ARAC_ASSERT_IMP(a_rnd_bound, clk, rst, state == ST_RUN, rnd <= 5'(ROUNDS))
  `ARAC_ASSERT_IMP(a_hold_out, clk, rst, out_valid && !out_ready, !q_ready)
endmodule

[hdl/aes_round_aead_cipher.sv]
// Order: an accepted request is written into a queue entry; the core takes it
// into the rounds, then registers the enc/dec result or, after the finalize
// rounds, the tag. Throughput: one ad/enc/dec request per cycle through the
// single round datapath when the output is free; init and finalize keep it busy.
// Reset: synchronous rst clears key, state words, byte counts and queue.
// ----------------------------------------------------------------------------
// aes_round_aead_cipher: authenticated cipher top level
// ----------------------------------------------------------------------------
module aes_round_aead_cipher (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  arac_pkg::req_t in_req,
  output logic           out_valid,
  input  logic           out_ready,
  output arac_pkg::rsp_t out_rsp,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [63:0]    cfg_data
);
  import arac_pkg::*;

  logic [63:0] key_w [4];
  logic        q_valid, q_ready;
  req_t        q_req;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) key_w[i] <= '0;
    end else if (cfg_we) begin
      key_w[cfg_index] <= cfg_data;
    end
  end

  arac_front u_front (
    .clk(clk), .rst(rst), .valid(in_valid), .ready(in_ready), .req(in_req),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
  );

  arac_core u_core (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .key({key_w[3], key_w[2], key_w[1], key_w[0]}),
    .out_valid(out_valid), .out_ready(out_ready), .rsp(out_rsp)
  );
endmodule
